/* rtl/abps_pkg.sv */
package abps_pkg;

  // field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned FreqW  = 15;
  localparam int unsigned LenW   = 16;
  localparam int unsigned CountW = 4;
  localparam int unsigned LevelW = 2;

  // configuration port
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WARN_FREQ = 4'd0,
    REG_WARN_TONE = 4'd1,
    REG_WARN_GAP  = 4'd2,
    REG_WARN_BEEPS = 4'd3,
    REG_CRIT_FREQ = 4'd4,
    REG_CRIT_TONE = 4'd5,
    REG_CRIT_GAP  = 4'd6,
    REG_CRIT_BEEPS = 4'd7
  } reg_idx_t;

  // register reset values
  localparam logic [FreqW-1:0]  WarnFreqRst  = 15'd880;
  localparam logic [LenW-1:0]   WarnToneRst  = 16'd200;
  localparam logic [LenW-1:0]   WarnGapRst   = 16'd250;
  localparam logic [CountW-1:0] WarnBeepsRst = 4'd2;
  localparam logic [FreqW-1:0]  CritFreqRst  = 15'd1500;
  localparam logic [LenW-1:0]   CritToneRst  = 16'd400;
  localparam logic [LenW-1:0]   CritGapRst   = 16'd200;
  localparam logic [CountW-1:0] CritBeepsRst = 4'd3;

  // alert level that selects the critical pattern
  localparam logic [LevelW-1:0] LevelCrit = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BEEP = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

endpackage

/* rtl/abps_tick_if.sv */
interface abps_tick_if;
  import abps_pkg::*;

  logic              valid;
  logic              ready;
  logic [TimeW-1:0]  now_ms;
  logic              cmd_valid;
  logic [LevelW-1:0] cmd_level;

  modport source (output valid, now_ms, cmd_valid, cmd_level, input ready);
  modport sink   (input valid, now_ms, cmd_valid, cmd_level, output ready);
endinterface

/* rtl/abps_res_if.sv */
interface abps_res_if;
  import abps_pkg::*;

  logic             valid;
  logic             ready;
  logic             cmd_accepted;
  logic             tone_start;
  logic [FreqW-1:0] tone_freq_hz;
  logic [LenW-1:0]  tone_length_ms;
  logic             busy_res;

  modport source (output valid, cmd_accepted, tone_start, tone_freq_hz, tone_length_ms,
                  busy_res, input ready);
  modport sink   (input valid, cmd_accepted, tone_start, tone_freq_hz, tone_length_ms,
                  busy_res, output ready);
endinterface

/* rtl/abps_cfg_if.sv */
interface abps_cfg_if;
  import abps_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/alarm_beep_pattern_sequencer.sv */
// Buzzer pattern sequencer, one tick word per step.
// tick: each word carries the millisecond time now_ms and an optional alert
//   command (cmd_valid, cmd_level). A command is taken only while idle;
//   cmd_accepted in the result tells the sender to drop it.
// res: one result word per tick word: tone_start with frequency and length
//   when a beep must begin, and busy_res while a pattern is in progress.
// cfg: register writes (index 0..7, warning then critical pattern); other
//   indices are ignored. Writes are always taken, and are meant for idle.
// Pipeline: a tick word is registered at its acceptance and its result is
//   registered when the result register is free or being taken. One tick
//   word per cycle is sustained while res.ready holds: the phase update is
//   one compare and one three-input add between the input and result registers.
// Reset (rst, synchronous): phase idle, registers to their default patterns,
//   both pipeline registers empty.
// A stalled receiver holds the result register; the input register fills
//   behind it and tick.ready then drops until the result is taken.
module alarm_beep_pattern_sequencer (
  input  logic        clk,
  input  logic        rst,
  abps_tick_if.sink   tick,
  abps_res_if.source  res,
  abps_cfg_if.sink    cfg
);
  import abps_pkg::*;

  // configuration registers
  logic [FreqW-1:0]  warn_freq_hz, crit_freq_hz;
  logic [LenW-1:0]   warn_tone_ms, warn_gap_ms, crit_tone_ms, crit_gap_ms;
  logic [CountW-1:0] warn_beeps, crit_beeps;

  // input register
  logic              in_valid;
  logic [TimeW-1:0]  in_now;
  logic              in_cmd;
  logic [LevelW-1:0] in_level;

  // sequencer state
  phase_t            phase, phase_next;
  logic [FreqW-1:0]  pattern_freq, pattern_freq_next;
  logic [LenW-1:0]   pattern_tone_len, pattern_tone_len_next;
  logic [LenW-1:0]   pattern_gap_len, pattern_gap_len_next;
  logic [CountW-1:0] beeps_remaining, beeps_remaining_next;
  logic [TimeW-1:0]  due_time, due_time_next;

  // step outputs
  logic             step_accepted, step_start;
  logic [FreqW-1:0] step_freq;
  logic [LenW-1:0]  step_len;
  logic             due;
  logic             step_fire, in_load;

  assign cfg.ready  = 1'b1;
  assign step_fire  = in_valid && (!res.valid || res.ready);
  assign in_load    = tick.valid && tick.ready;
  assign tick.ready = !in_valid || step_fire;
  assign due        = in_now >= due_time;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      warn_freq_hz <= WarnFreqRst;
      warn_tone_ms <= WarnToneRst;
      warn_gap_ms  <= WarnGapRst;
      warn_beeps   <= WarnBeepsRst;
      crit_freq_hz <= CritFreqRst;
      crit_tone_ms <= CritToneRst;
      crit_gap_ms  <= CritGapRst;
      crit_beeps   <= CritBeepsRst;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_WARN_FREQ:  warn_freq_hz <= cfg.data[FreqW-1:0];
        REG_WARN_TONE:  warn_tone_ms <= cfg.data[LenW-1:0];
        REG_WARN_GAP:   warn_gap_ms  <= cfg.data[LenW-1:0];
        REG_WARN_BEEPS: warn_beeps   <= cfg.data[CountW-1:0];
        REG_CRIT_FREQ:  crit_freq_hz <= cfg.data[FreqW-1:0];
        REG_CRIT_TONE:  crit_tone_ms <= cfg.data[LenW-1:0];
        REG_CRIT_GAP:   crit_gap_ms  <= cfg.data[LenW-1:0];
        REG_CRIT_BEEPS: crit_beeps   <= cfg.data[CountW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= 1'b1;
    end else if (step_fire) begin
      in_valid <= 1'b0;
    end
    if (in_load) begin
      in_now   <= tick.now_ms;
      in_cmd   <= tick.cmd_valid;
      in_level <= tick.cmd_level;
    end
  end

  // next state and pattern registers
  always_comb begin
    phase_next            = phase;
    pattern_freq_next     = pattern_freq;
    pattern_tone_len_next = pattern_tone_len;
    pattern_gap_len_next  = pattern_gap_len;
    beeps_remaining_next  = beeps_remaining;
    due_time_next         = due_time;
    unique case (phase)
      PH_BEEP: begin
        if (due) begin
          if (beeps_remaining != '0) begin
            beeps_remaining_next = beeps_remaining - CountW'(1);
          end
          due_time_next = in_now + TimeW'(pattern_tone_len) + TimeW'(pattern_gap_len);
          phase_next    = PH_GAP;
        end
      end
      PH_GAP: begin
        if (due) begin
          if (beeps_remaining != '0) begin
            due_time_next = in_now;
            phase_next    = PH_BEEP;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (in_cmd) begin
          if (in_level == LevelCrit) begin
            pattern_freq_next     = crit_freq_hz;
            pattern_tone_len_next = crit_tone_ms;
            pattern_gap_len_next  = crit_gap_ms;
            beeps_remaining_next  = crit_beeps;
          end else begin
            pattern_freq_next     = warn_freq_hz;
            pattern_tone_len_next = warn_tone_ms;
            pattern_gap_len_next  = warn_gap_ms;
            beeps_remaining_next  = warn_beeps;
          end
          due_time_next = in_now;
          phase_next    = PH_BEEP;
        end
      end
    endcase
  end

  // step outputs
  always_comb begin
    step_accepted = 1'b0;
    step_start    = 1'b0;
    step_freq     = '0;
    step_len      = '0;
    unique case (phase)
      PH_BEEP: begin
        if (due) begin
          step_start = 1'b1;
          step_freq  = pattern_freq;
          step_len   = pattern_tone_len;
        end
      end
      PH_GAP: ;
      default: step_accepted = in_cmd;
    endcase
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      pattern_freq     <= '0;
      pattern_tone_len <= '0;
      pattern_gap_len  <= '0;
      beeps_remaining  <= '0;
      due_time         <= '0;
    end else if (step_fire) begin
      phase            <= phase_next;
      pattern_freq     <= pattern_freq_next;
      pattern_tone_len <= pattern_tone_len_next;
      pattern_gap_len  <= pattern_gap_len_next;
      beeps_remaining  <= beeps_remaining_next;
      due_time         <= due_time_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (step_fire) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
    if (step_fire) begin
      res.cmd_accepted   <= step_accepted;
      res.tone_start     <= step_start;
      res.tone_freq_hz   <= step_freq;
      res.tone_length_ms <= step_len;
      res.busy_res       <= phase_next != PH_IDLE;
    end
  end

  // checks
  a_start_busy : assert property (@(posedge clk) disable iff (rst)
    res.valid && res.tone_start |-> res.busy_res)
    else $error("tone started but sequencer not busy");

  a_accept_no_tone : assert property (@(posedge clk) disable iff (rst)
    res.valid && res.cmd_accepted |-> res.busy_res && !res.tone_start)
    else $error("accepted command with tone or without busy");

  a_quiet_fields : assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.tone_start |-> res.tone_freq_hz == '0 && res.tone_length_ms == '0)
    else $error("tone fields set without tone start");

  a_reset_idle : assert property (@(posedge clk)
    rst |=> phase == PH_IDLE && !res.valid && !in_valid)
    else $error("state not cleared by reset");

  a_busy_tracks_phase : assert property (@(posedge clk) disable iff (rst)
    step_fire |=> res.busy_res == (phase != PH_IDLE))
    else $error("busy flag disagrees with phase");

endmodule
